### hdl/rotation_matrix_to_quaternion_unit_assert.svh
// Assertion macros shared by the quaternion unit modules.
// Each expects aclk and aresetn in scope.
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH

// Condition that must hold at every edge outside reset
`define RMQ_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent
`define RMQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/rmq_pkg.sv
package rmq_pkg;

    // Q2.14 unity
    localparam logic signed [17:0] Q_ONE = 18'sd16384;

    localparam int THR_W      = 14;
    localparam int RAD_W      = 17;   // clamped radicand
    localparam int NUM_W      = 17;   // pair sum or difference
    localparam int ROOT_W     = 16;
    localparam int SQ_IN_W    = 2 * ROOT_W;
    localparam int SQ_STEPS   = ROOT_W;
    localparam int DV_STEPS   = 15;   // quotient bits below the saturation point
    localparam int LANES      = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Output slot that receives the root term
    typedef enum logic [1:0] {
        SLOT_X = 2'd0,
        SLOT_Y = 2'd1,
        SLOT_Z = 2'd2,
        SLOT_W = 2'd3
    } slot_t;

    // Classified item: numerators go to the non-root slots in ascending order
    typedef struct packed {
        logic [RAD_W-1:0]                  rad;
        slot_t                             root_slot;
        logic [LANES-1:0][NUM_W-1:0]       nums;
    } job_t;

endpackage

### hdl/rmq_front.sv
module rmq_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [143:0]                  s_tdata,   // m00 m10 m20 m01 m11 m21 m02 m12 m22
    input  logic [rmq_pkg::THR_W-1:0]     threshold,
    output logic                          push_valid,
    input  logic                          push_ready,
    output rmq_pkg::job_t                 push_job
);
    import rmq_pkg::*;

    logic signed [15:0] m00, m10, m20, m01, m11, m21, m02, m12, m22;
    logic signed [17:0] trace_p1, d0, d1, d2, d_sel;
    logic               direct, br0, br1;

    assign m00 = s_tdata[15:0];
    assign m10 = s_tdata[31:16];
    assign m20 = s_tdata[47:32];
    assign m01 = s_tdata[63:48];
    assign m11 = s_tdata[79:64];
    assign m21 = s_tdata[95:80];
    assign m02 = s_tdata[111:96];
    assign m12 = s_tdata[127:112];
    assign m22 = s_tdata[143:128];

    // Radicands for each path
    assign trace_p1 = 18'(m00) + 18'(m11) + 18'(m22) + Q_ONE;
    assign d0 = Q_ONE + 18'(m00) - 18'(m11) - 18'(m22);
    assign d1 = Q_ONE + 18'(m11) - 18'(m00) - 18'(m22);
    assign d2 = Q_ONE + 18'(m22) - 18'(m00) - 18'(m11);

    assign direct = trace_p1 > $signed({4'b0000, threshold});
    assign br0    = (m00 > m11) && (m00 > m22);
    assign br1    = m11 > m22;

    // Path selection and numerators
    always_comb begin
        push_job = '0;
        if (direct) begin
            d_sel = trace_p1;
            push_job.root_slot = SLOT_W;
            push_job.nums[0] = 17'(m21) - 17'(m12);
            push_job.nums[1] = 17'(m02) - 17'(m20);
            push_job.nums[2] = 17'(m10) - 17'(m01);
        end else if (br0) begin
            d_sel = d0;
            push_job.root_slot = SLOT_X;
            push_job.nums[0] = 17'(m10) + 17'(m01);
            push_job.nums[1] = 17'(m02) + 17'(m20);
            push_job.nums[2] = 17'(m21) - 17'(m12);
        end else if (br1) begin
            d_sel = d1;
            push_job.root_slot = SLOT_Y;
            push_job.nums[0] = 17'(m10) + 17'(m01);
            push_job.nums[1] = 17'(m21) + 17'(m12);
            push_job.nums[2] = 17'(m02) - 17'(m20);
        end else begin
            d_sel = d2;
            push_job.root_slot = SLOT_Z;
            push_job.nums[0] = 17'(m02) + 17'(m20);
            push_job.nums[1] = 17'(m21) + 17'(m12);
            push_job.nums[2] = 17'(m10) - 17'(m01);
        end
        // negative radicand counts as zero
        push_job.rad = d_sel[17] ? '0 : d_sel[RAD_W-1:0];
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

### hdl/rmq_fifo.sv
`include "rotation_matrix_to_quaternion_unit_assert.svh"

module rmq_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  rmq_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop_ready,
    output rmq_pkg::job_t pop_job
);
    import rmq_pkg::*;

    job_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_fire, pop_fire;

    assign push_ready = count_reg != CNT_W'(FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_job    = mem[rd_ptr_reg];

    // Pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_fire);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop_fire);
        count_next  = count_reg + CNT_W'(push_fire) - CNT_W'(pop_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push_fire) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    `RMQ_ASSERT_ALWAYS(a_fifo_bound, count_reg <= CNT_W'(FIFO_DEPTH), "fifo count overflow")
    `RMQ_ASSERT_NEXT(a_fifo_inc, push_fire && !pop_fire, count_reg == $past(count_reg) + CNT_W'(1), "fifo count missed push")
    `RMQ_ASSERT_NEXT(a_fifo_dec, pop_fire && !push_fire, count_reg == $past(count_reg) - CNT_W'(1), "fifo count missed pop")

endmodule

### hdl/rmq_back.sv
`include "rotation_matrix_to_quaternion_unit_assert.svh"

module rmq_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  rmq_pkg::job_t pop_job,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata    // qx qy qz qw
);
    import rmq_pkg::*;

    logic en;

    // Square root stages
    logic                      sq_v    [SQ_STEPS+1];
    logic [SQ_IN_W-1:0]        sq_rad  [SQ_STEPS+1];
    logic [ROOT_W+1:0]         sq_rem  [SQ_STEPS+1];
    logic [ROOT_W-1:0]         sq_root [SQ_STEPS+1];
    job_t                      sq_job  [SQ_STEPS+1];

    // Divider stages
    logic                                dv_v    [DV_STEPS+1];
    logic [LANES-1:0][NUM_W-1:0]         dv_rem  [DV_STEPS+1];
    logic [LANES-1:0][DV_STEPS-1:0]      dv_low  [DV_STEPS+1];
    logic [LANES-1:0][DV_STEPS-1:0]      dv_q    [DV_STEPS+1];
    logic [LANES-1:0]                    dv_neg  [DV_STEPS+1];
    logic [LANES-1:0]                    dv_ovf  [DV_STEPS+1];
    logic [ROOT_W:0]                     dv_s    [DV_STEPS+1];
    slot_t                               dv_slot [DV_STEPS+1];

    logic        out_valid_reg;
    logic [63:0] out_data_reg, out_data_next;

    assign en        = !out_valid_reg || m_tready;
    assign pop_ready = en;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Entry into the root pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v[0] <= 1'b0;
        end else if (en) begin
            sq_v[0] <= pop_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_rad[0]  <= {1'b0, pop_job.rad, 14'd0};
            sq_rem[0]  <= '0;
            sq_root[0] <= '0;
            sq_job[0]  <= pop_job;
        end
    end

    // One root digit per stage
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        logic [ROOT_W+3:0] cur, trial;
        logic [ROOT_W+1:0] rem_n;
        logic [ROOT_W-1:0] root_n;

        always_comb begin
            cur   = {sq_rem[k], sq_rad[k][SQ_IN_W-1 -: 2]};
            trial = {2'b00, sq_root[k], 2'b01};
            if (cur >= trial) begin
                rem_n  = (ROOT_W+2)'(cur - trial);
                root_n = {sq_root[k][ROOT_W-2:0], 1'b1};
            end else begin
                rem_n  = cur[ROOT_W+1:0];
                root_n = {sq_root[k][ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v[k+1] <= 1'b0;
            end else if (en) begin
                sq_v[k+1] <= sq_v[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_rad[k+1]  <= {sq_rad[k][SQ_IN_W-3:0], 2'b00};
                sq_rem[k+1]  <= rem_n;
                sq_root[k+1] <= root_n;
                sq_job[k+1]  <= sq_job[k];
            end
        end
    end

    // Divider setup: magnitude, sign, saturation check
    logic [ROOT_W:0]             s_w;
    logic [LANES-1:0][NUM_W-1:0] mag_w;
    logic [LANES-1:0]            neg_w, ovf_w;

    assign s_w = {sq_root[SQ_STEPS], 1'b0};

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            neg_w[i] = sq_job[SQ_STEPS].nums[i][NUM_W-1];
            mag_w[i] = neg_w[i] ? (~sq_job[SQ_STEPS].nums[i] + NUM_W'(1))
                                : sq_job[SQ_STEPS].nums[i];
            ovf_w[i] = {1'b0, mag_w[i]} >= {s_w, 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v[0] <= 1'b0;
        end else if (en) begin
            dv_v[0] <= sq_v[SQ_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < LANES; i++) begin
                dv_rem[0][i] <= {1'b0, mag_w[i][NUM_W-1:1]};
                dv_low[0][i] <= {mag_w[i][0], 14'd0};
                dv_q[0][i]   <= '0;
            end
            dv_neg[0]  <= neg_w;
            dv_ovf[0]  <= ovf_w;
            dv_s[0]    <= s_w;
            dv_slot[0] <= sq_job[SQ_STEPS].root_slot;
        end
    end

    // One quotient bit per stage, three lanes
    for (genvar k = 0; k < DV_STEPS; k++) begin : g_dv
        logic [LANES-1:0][NUM_W-1:0]    rem_n;
        logic [LANES-1:0][DV_STEPS-1:0] q_n;
        logic [NUM_W:0]                 cur;

        always_comb begin
            for (int i = 0; i < LANES; i++) begin
                cur = {dv_rem[k][i], dv_low[k][i][DV_STEPS-1]};
                if (cur >= {1'b0, dv_s[k]}) begin
                    rem_n[i] = NUM_W'(cur - {1'b0, dv_s[k]});
                    q_n[i]   = {dv_q[k][i][DV_STEPS-2:0], 1'b1};
                end else begin
                    rem_n[i] = cur[NUM_W-1:0];
                    q_n[i]   = {dv_q[k][i][DV_STEPS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v[k+1] <= 1'b0;
            end else if (en) begin
                dv_v[k+1] <= dv_v[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < LANES; i++) begin
                    dv_low[k+1][i] <= {dv_low[k][i][DV_STEPS-2:0], 1'b0};
                end
                dv_rem[k+1]  <= rem_n;
                dv_q[k+1]    <= q_n;
                dv_neg[k+1]  <= dv_neg[k];
                dv_ovf[k+1]  <= dv_ovf[k];
                dv_s[k+1]    <= dv_s[k];
                dv_slot[k+1] <= dv_slot[k];
            end
        end
    end

    // Saturation, zero divisor and slot placement
    logic [LANES-1:0][15:0] lane_q;
    logic [15:0]            root_q;
    logic                   zero_div;

    always_comb begin
        zero_div = dv_s[DV_STEPS] == '0;
        root_q   = {1'b0, dv_s[DV_STEPS][ROOT_W:2]};
        for (int i = 0; i < LANES; i++) begin
            if (zero_div) begin
                lane_q[i] = '0;
            end else if (dv_ovf[DV_STEPS][i]) begin
                lane_q[i] = dv_neg[DV_STEPS][i] ? 16'h8000 : 16'h7FFF;
            end else if (dv_neg[DV_STEPS][i]) begin
                lane_q[i] = ~{1'b0, dv_q[DV_STEPS][i]} + 16'd1;
            end else begin
                lane_q[i] = {1'b0, dv_q[DV_STEPS][i]};
            end
        end
        case (dv_slot[DV_STEPS])
            SLOT_X:  out_data_next = {lane_q[2], lane_q[1], lane_q[0], root_q};
            SLOT_Y:  out_data_next = {lane_q[2], lane_q[1], root_q, lane_q[0]};
            SLOT_Z:  out_data_next = {lane_q[2], root_q, lane_q[1], lane_q[0]};
            SLOT_W:  out_data_next = {root_q, lane_q[2], lane_q[1], lane_q[0]};
            default: out_data_next = '0;
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv_v[DV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= out_data_next;
        end
    end

    `RMQ_ASSERT_NEXT(a_back_hold, out_valid_reg && !en, out_valid_reg && $stable(sq_v[0]), "back pipeline moved while stalled")

endmodule

### hdl/rotation_matrix_to_quaternion_unit.sv
// Channel    Dir  Payload                                  Handshake
// s_*        in   144b: m00 m10 m20 m01 m11 m21 m02 m12 m22  s_tvalid / s_tready
// m_*        out  64b:  qx qy qz qw                           m_tvalid / m_tready
// APB        in   trace_threshold at byte address 0           psel / penable / pready
//
// One item per cycle sustained while m_tready stays high; from accept to result an item passes
// the 4-entry queue, 16 root stages, 15 divider stages and the output register.
// Synchronous active-low reset clears all valid flags and sets the threshold to 2.
// A stalled output freezes the back pipeline; input keeps flowing until the queue fills.
module rotation_matrix_to_quaternion_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,    // m00 m10 m20 m01 m11 m21 m02 m12 m22
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,    // qx qy qz qw
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import rmq_pkg::*;

    localparam logic [1:0]       ADDR_THRESH = 2'd0;
    localparam logic [THR_W-1:0] THR_RESET   = 14'd2;

    logic [THR_W-1:0] thr_reg, thr_next;
    logic             push_valid, push_ready, pop_valid, pop_ready;
    job_t             push_job, pop_job;

    // Configuration register
    assign pready = 1'b1;

    always_comb begin
        thr_next = thr_reg;
        if (psel && penable && pwrite && pready && paddr == ADDR_THRESH) begin
            thr_next = pwdata[THR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else begin
            thr_reg <= thr_next;
        end
    end

    assign prdata = (paddr == ADDR_THRESH) ? {18'd0, thr_reg} : 32'd0;

    rmq_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .threshold (thr_reg),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_job  (push_job)
    );

    rmq_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_job  (push_job),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job)
    );

    rmq_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_job  (pop_job),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
